@@ hdl/wfa_pkg.sv @@
// ----------------------------------------------------------------------------
// wfa_pkg: shared types, constants and helpers of the wavefront allocator
// Holds the matrix geometry, the register map and the cell helper functions
// used by the sweep logic and the priority-line control.
// ----------------------------------------------------------------------------
package wfa_pkg;

    // Matrix geometry
    localparam int NUM_CLIENTS   = 8;
    localparam int NUM_RESOURCES = 8;
    localparam int ROWS = (NUM_CLIENTS > NUM_RESOURCES) ? NUM_CLIENTS : NUM_RESOURCES;
    localparam int COLS = (NUM_CLIENTS > NUM_RESOURCES) ? NUM_RESOURCES : NUM_CLIENTS;
    localparam bit CLIENT_IS_ROW = (NUM_CLIENTS > NUM_RESOURCES);

    // Field widths
    localparam int MAT_W     = 64;
    localparam int BIT_IDX_W = 6;
    localparam int LINE_W    = 3;
    localparam int OUT_W     = MAT_W + LINE_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_W;

    // Pseudo-random line source
    localparam int LFSR_W = 16;
    localparam logic [LFSR_W-1:0] LFSR_RESET = 16'hACE1;
    // width of the weighted bit sum used to reduce the LFSR modulo ROWS
    localparam int MOD_SUM_W = 7;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_MODE = '0;

    // Priority modes
    localparam logic MODE_SEQ  = 1'b0;
    localparam logic MODE_RAND = 1'b1;

    typedef logic [MAT_W-1:0]  mat_t;
    typedef logic [LINE_W-1:0] line_t;

    typedef struct packed {
        logic                  sel;
        logic                  enable;
        logic                  write;
        logic [APB_ADDR_W-1:0] addr;
        logic [APB_DATA_W-1:0] wdata;
    } apb_req_t;

    // Matrix bit that holds cell (row, col)
    function automatic logic [BIT_IDX_W-1:0] cell_bit(input int row, input int col);
        int client;
        int resource;
        begin
            if (CLIENT_IS_ROW)
            begin
                client   = row;
                resource = col;
            end
            else
            begin
                client   = col;
                resource = row;
            end
            cell_bit = BIT_IDX_W'(client * NUM_RESOURCES + resource);
        end
    endfunction

    // Diagonal of cell (row, col): (row + col) modulo ROWS
    function automatic int cell_diag(input int row, input int col);
        int s;
        begin
            s = row + col;
            if (s >= ROWS)
                s = s - ROWS;
            cell_diag = s;
        end
    endfunction

    // 2**k modulo ROWS, by repeated doubling
    function automatic int pow2_mod_rows(input int k);
        int w;
        begin
            w = (ROWS == 1) ? 0 : 1;
            for (int i = 0; i < k; i++)
            begin
                w = w * 2;
                if (w >= ROWS)
                    w = w - ROWS;
            end
            pow2_mod_rows = w;
        end
    endfunction

endpackage

@@ hdl/wfa_array.sv @@
// ----------------------------------------------------------------------------
// wfa_array: wavefront sweep over the request matrix
// Visits the diagonals in order from the priority line; a requested cell is
// granted when its row and column are both still free.
// ----------------------------------------------------------------------------
module wfa_array
    import wfa_pkg::*;
(
    input  mat_t  request,
    input  line_t first_line,
    output mat_t  grant
);

    // Sweep the diagonals; cells of one diagonal never share a row or column
    always_comb
    begin
        logic [ROWS-1:0] row_busy;
        logic [COLS-1:0] col_busy;
        int              ln;
        row_busy = '0;
        col_busy = '0;
        grant    = '0;
        for (int off = 0; off < ROWS; off++)
        begin
            ln = int'(first_line) + off;
            if (ln >= ROWS)
                ln = ln - ROWS;
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    if ((cell_diag(r, c) == ln) && request[cell_bit(r, c)]
                        && !row_busy[r] && !col_busy[c])
                    begin
                        grant[cell_bit(r, c)] = 1'b1;
                        row_busy[r] = 1'b1;
                        col_busy[c] = 1'b1;
                    end
                end
            end
        end
    end

endmodule

@@ hdl/wfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// wfa_ctrl: mode register and priority-line control
// Holds the mode register behind the configuration port, the starting line
// and the LFSR that supplies lines in random mode.
// ----------------------------------------------------------------------------
module wfa_ctrl
    import wfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  apb_req_t              apb,
    output logic [APB_DATA_W-1:0] rdata,
    input  logic                  advance,
    output line_t                 start_line
);

    logic              mode_reg;
    logic              mode_next;
    line_t             line_reg;
    line_t             line_next;
    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_next;
    logic [LFSR_W-1:0] lfsr_step;
    line_t             lfsr_line;
    logic              mode_hit;

    assign mode_hit = (apb.addr[APB_ADDR_W-1:2] == REG_MODE);

    // Write the mode register on the access phase of a write
    always_comb
    begin
        mode_next = mode_reg;
        if (apb.sel && apb.enable && apb.write && mode_hit)
            mode_next = apb.wdata[0];
    end

    // Read back
    assign rdata = mode_hit ? APB_DATA_W'(mode_reg) : '0;

    // Step the Fibonacci LFSR, taps 16, 14, 13, 11
    assign lfsr_step = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                        lfsr_reg[LFSR_W-1:1]};

    // Reduce the stepped LFSR modulo ROWS: weighted bit sum, then subtract
    always_comb
    begin
        logic [MOD_SUM_W-1:0] v;
        v = '0;
        for (int k = 0; k < LFSR_W; k++)
        begin
            if (lfsr_step[k])
                v = v + MOD_SUM_W'(pow2_mod_rows(k));
        end
        for (int k = MOD_SUM_W - 1; k >= 0; k--)
        begin
            if (int'(v) >= (ROWS << k))
                v = v - MOD_SUM_W'(ROWS << k);
        end
        lfsr_line = LINE_W'(v);
    end

    // Advance the line once per accepted item
    always_comb
    begin
        line_next = line_reg;
        lfsr_next = lfsr_reg;
        if (advance)
        begin
            if (mode_reg == MODE_RAND)
            begin
                lfsr_next = lfsr_step;
                line_next = lfsr_line;
            end
            else if (int'(line_reg) == ROWS - 1)
                line_next = '0;
            else
                line_next = line_reg + line_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SEQ;
            line_reg <= '0;
            lfsr_reg <= LFSR_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            lfsr_reg <= lfsr_next;
        end
    end

    assign start_line = line_reg;

    // The LFSR never locks up at zero
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("LFSR reached zero");

    // Line always stays inside the matrix
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(line_reg) < ROWS)
        else $error("starting line out of range");

    // Sequential mode wraps the line by one per item
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_reg == MODE_SEQ) |=>
        (line_reg == ((int'($past(line_reg)) == ROWS - 1) ? line_t'(0)
                                                          : $past(line_reg) + line_t'(1))))
        else $error("sequential line step wrong");

endmodule

@@ hdl/wavefront_allocator_core.sv @@
// ----------------------------------------------------------------------------
// wavefront_allocator_core: one-pass wavefront allocator
// Takes a client-by-resource request matrix per transfer and returns a grant
// matrix with at most one grant per row and column, plus the priority line.
//
//   channel  direction  transfer                 payload
//   s_*      in         s_tvalid && s_tready     request_matrix
//   m_*      out        m_tvalid && m_tready     grant_matrix, line_used
//   apb      in/out     psel/penable/pwrite      priority_mode (addr 0)
//
// One item per clock sustained while m_tready is high. An item passes the input
// register, then the diagonal sweep into the result register, whose load
// raises m_tvalid. The full sweep of all diagonals sits between those registers.
// Reset clears the valid flags of both stages, the line to zero and the LFSR to its seed.
// A stalled output holds its result while one more item waits in the input
// register; s_tready drops only when both stages are full and m_tready is low.
// ----------------------------------------------------------------------------
module wavefront_allocator_core
    import wfa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [MAT_W-1:0]       s_tdata,   // [63:0] request_matrix
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [63:0] grant_matrix, [66:64] line_used
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic     s1_valid_reg;
    logic     s1_valid_next;
    mat_t     s1_req_reg;
    line_t    s1_line_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    mat_t     out_grant_reg;
    line_t    out_line_reg;
    logic     out_free;
    logic     s1_adv;
    logic     in_xfer;
    line_t    start_line;
    mat_t     grant;
    apb_req_t apb;

    assign pready = 1'b1;
    assign apb    = '{sel: psel, enable: penable, write: pwrite, addr: paddr, wdata: pwdata};

    wfa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .apb        (apb),
        .rdata      (prdata),
        .advance    (in_xfer),
        .start_line (start_line)
    );

    wfa_array u_array (
        .request    (s1_req_reg),
        .first_line (s1_line_reg),
        .grant      (grant)
    );

    // Handshake between the two stages
    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request with the line in force at its transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_req_reg  <= s_tdata;
            s1_line_reg <= start_line;
        end
    end

    // Load the sweep result
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_grant_reg <= grant;
            out_line_reg  <= s1_line_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_line_reg, out_grant_reg};

    // Grants only where requested
    a_grant_subset: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> ((out_grant_reg & ~$past(s1_req_reg)) == '0))
        else $error("grant without request");

    // Empty input stage always takes a transfer
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled while empty");

    // Reported line lies inside the matrix
    a_line_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (int'(out_line_reg) < ROWS))
        else $error("line_used out of range");

endmodule
